>>> rtl/core/llmt_pkg.sv
// Package for the Lucas-Lehmer Mersenne test block: word size, exponent width,
// default exponent limit and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package llmt_pkg;

  localparam int unsigned WORD_W = 64;               // datapath word
  localparam int unsigned WORD_LW = $clog2(WORD_W);  // bits of a bit offset in a word
  localparam int unsigned EXP_W = 11;                // exponent field width
  localparam int unsigned MAX_EXPONENT_DEF = 1024;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_INIT  = 10'b00_0000_0010,
    ST_COPY  = 10'b00_0000_0100,
    ST_LOAD  = 10'b00_0000_1000,
    ST_LOAD2 = 10'b00_0001_0000,
    ST_MAC   = 10'b00_0010_0000,
    ST_SUB2  = 10'b00_0100_0000,
    ST_FOLD  = 10'b00_1000_0000,
    ST_CHECK = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } llmt_state_e;

endpackage

>>> rtl/core/lucas_lehmer_mersenne_test_top.sv
// Lucas-Lehmer Mersenne test: top level with word-serial modular adder,
// sequencer and three word memories. Depends on llmt_pkg.
`timescale 1ns / 1ps

// One item is an exponent p; the block answers whether 2^p-1 is prime. The
// residue s lives in memory as ceil(p/64) words of 64 bits and starts at 4.
// Each of the p-2 Lucas-Lehmer steps squares s modulo 2^p-1 by shift-and-add:
// for every bit i of s, a copy of s doubled i times (a p-bit rotate) is added
// into an accumulator when that bit is set. All additions go through one
// 64-bit adder, one word per cycle, with the carry out of bit p-1 kept as a
// pending carry and fed back in at bit 0 of the next pass (end-around carry).
// Subtracting 2 is one more pass that adds 2^p-1-2, then at most one further
// pass folds the pending carry. The answer is "prime" when the final residue
// is all zeros or all ones. Exponents 0, 1 and any above MAX_EXPONENT answer
// not prime, 2 answers prime, each without any pass.
// The input is ready only while the block is idle; a finished result waits in
// the output register, so the next exponent may be accepted before it is taken.
module lucas_lehmer_mersenne_test_top #(
  parameter int unsigned MAX_EXPONENT = llmt_pkg::MAX_EXPONENT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [llmt_pkg::EXP_W-1:0] exponent_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       is_prime_o
);

  localparam int unsigned W = llmt_pkg::WORD_W;
  localparam int unsigned LW = llmt_pkg::WORD_LW;
  localparam int unsigned EW = llmt_pkg::EXP_W;
  localparam int unsigned NumWords = (MAX_EXPONENT + W - 1) / W;
  localparam int unsigned AW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned CW = AW + 1;

  llmt_pkg::llmt_state_e state_q, state_d;

  logic [EW-1:0] p_q, p_d;      // exponent
  logic [CW-1:0] nw_q, nw_d;    // words in use
  logic [LW-1:0] tb_q, tb_d;    // p mod word size
  logic [EW-1:0] it_q, it_d;    // steps left
  logic [EW-1:0] bi_q, bi_d;    // multiplier bit
  logic [W-1:0]  sw_q, sw_d;    // multiplier word, shifted per bit
  logic [CW-1:0] rk_q, rk_d;    // read word index
  logic          sv_q, sv_d;    // write stage holds a word
  logic [AW-1:0] wk_q, wk_d;    // write word index
  logic          cy_q, cy_d;    // carry between words
  logic          am_q, am_d;    // msb of previous copy word
  logic          atop_q, atop_d; // bit p-1 of the shifted copy
  logic          pend_q, pend_d; // pending end-around carry
  logic          zr_q, zr_d;
  logic          on_q, on_d;
  logic          pr_q, pr_d;    // answer waiting for the output register
  logic          ov_q, ov_d;
  logic          res_q, res_d;

  // word memories: shifted copy, accumulator, multiplier residue
  logic [W-1:0] a_mem [NumWords];
  logic [W-1:0] c_mem [NumWords];
  logic [W-1:0] r_mem [NumWords];
  logic [W-1:0] a_rd_q, c_rd_q, r_rd_q;
  logic         a_we, c_we, r_we;
  logic [W-1:0] a_wd, c_wd;
  logic [AW-1:0] rd_addr, r_raddr;

  // datapath
  logic [W-1:0]  top_mask, addend, sum_word, shifted, sh_word;
  logic [W:0]    sum;
  logic [LW:0]   oidx;
  logic [LW-1:0] tidx;
  logic          last, cin, sin, ncy, pass_end, in_pass;
  logic          zr_n, on_n;
  logic [EW:0]   nw_full;
  logic [EW-1:0] bi_inc;

  assign in_ready_o  = (state_q == llmt_pkg::ST_IDLE);
  assign out_valid_o = ov_q;
  assign is_prime_o  = res_q;

  assign top_mask = (tb_q == '0) ? '1 : ((W'(1) << tb_q) - W'(1));
  assign last     = (CW'(wk_q) == (nw_q - CW'(1)));
  assign cin      = (wk_q == '0) ? pend_q : cy_q;
  assign sin      = (wk_q == '0) ? atop_q : am_q;
  assign oidx     = (tb_q == '0) ? (LW + 1)'(W) : {1'b0, tb_q};
  assign tidx     = tb_q - LW'(1);  // wraps to the msb for a full top word

  always_comb begin
    case (state_q)
      llmt_pkg::ST_MAC:  addend = sw_q[0] ? a_rd_q : '0;
      llmt_pkg::ST_SUB2: addend = ((wk_q == '0) ? ~W'(2) : '1) & (last ? top_mask : '1);
      default:           addend = '0;
    endcase
  end

  assign sum      = {1'b0, c_rd_q} + {1'b0, addend} + (W + 1)'(cin);
  assign sum_word = last ? (sum[W-1:0] & top_mask) : sum[W-1:0];
  assign ncy      = last ? sum[oidx] : sum[W];
  assign shifted  = {a_rd_q[W-2:0], sin};
  assign sh_word  = last ? (shifted & top_mask) : shifted;
  assign pass_end = sv_q && last;
  assign zr_n     = zr_q && (c_rd_q == '0);
  assign on_n     = on_q && (c_rd_q == (last ? top_mask : '1));
  assign nw_full  = ({1'b0, exponent_i} + (EW + 1)'(W - 1)) >> LW;
  assign bi_inc   = bi_q + EW'(1);

  assign in_pass = (state_q == llmt_pkg::ST_INIT) || (state_q == llmt_pkg::ST_COPY) ||
                   (state_q == llmt_pkg::ST_MAC) || (state_q == llmt_pkg::ST_SUB2) ||
                   (state_q == llmt_pkg::ST_FOLD) || (state_q == llmt_pkg::ST_CHECK);

  assign rd_addr = rk_q[AW-1:0];
  assign r_raddr = AW'(bi_q >> LW);

  // memory writes, all at the write stage index
  always_comb begin
    a_we = 1'b0;
    c_we = 1'b0;
    r_we = 1'b0;
    a_wd = sh_word;
    c_wd = sum_word;
    case (state_q)
      llmt_pkg::ST_INIT: begin
        c_we = sv_q;
        c_wd = (wk_q == '0) ? W'(4) : '0;
      end
      llmt_pkg::ST_COPY: begin
        a_we = sv_q;
        r_we = sv_q;
        c_we = sv_q;
        a_wd = c_rd_q;
        c_wd = '0;
      end
      llmt_pkg::ST_MAC: begin
        a_we = sv_q;
        c_we = sv_q;
      end
      llmt_pkg::ST_SUB2, llmt_pkg::ST_FOLD: begin
        c_we = sv_q;
      end
      default: begin
        a_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[wk_q] <= a_wd;
    end
    if (c_we) begin
      c_mem[wk_q] <= c_wd;
    end
    if (r_we) begin
      r_mem[wk_q] <= c_rd_q;
    end
    a_rd_q <= a_mem[rd_addr];
    c_rd_q <= c_mem[rd_addr];
    r_rd_q <= r_mem[r_raddr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    nw_d    = nw_q;
    tb_d    = tb_q;
    it_d    = it_q;
    bi_d    = bi_q;
    sw_d    = sw_q;
    rk_d    = rk_q;
    sv_d    = 1'b0;
    wk_d    = wk_q;
    cy_d    = cy_q;
    am_d    = am_q;
    atop_d  = atop_q;
    pend_d  = pend_q;
    zr_d    = zr_q;
    on_d    = on_q;
    pr_d    = pr_q;
    ov_d    = ov_q && !out_ready_i;
    res_d   = res_q;

    // word issue for every pass
    if (in_pass && (rk_q != nw_q)) begin
      rk_d = rk_q + CW'(1);
      sv_d = 1'b1;
      wk_d = rk_q[AW-1:0];
    end
    if (sv_q) begin
      cy_d = ncy;
      am_d = a_rd_q[W-1];
    end
    if (pass_end) begin
      rk_d = '0;
      sv_d = 1'b0;
    end

    case (state_q)
      llmt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          p_d  = exponent_i;
          nw_d = CW'(nw_full);
          tb_d = exponent_i[LW-1:0];
          it_d = exponent_i - EW'(2);
          rk_d = '0;
          pend_d = 1'b0;
          if ((exponent_i < EW'(3)) ||
              ({{(32 - EW){1'b0}}, exponent_i} > MAX_EXPONENT)) begin
            pr_d    = (exponent_i == EW'(2));
            state_d = llmt_pkg::ST_DONE;
          end else begin
            state_d = llmt_pkg::ST_INIT;
          end
        end
      end
      llmt_pkg::ST_INIT: begin
        if (pass_end) begin
          state_d = llmt_pkg::ST_COPY;
        end
      end
      llmt_pkg::ST_COPY: begin
        if (pass_end) begin
          atop_d  = c_rd_q[tidx];
          bi_d    = '0;
          state_d = llmt_pkg::ST_LOAD;
        end
      end
      llmt_pkg::ST_LOAD: begin
        state_d = llmt_pkg::ST_LOAD2;
      end
      llmt_pkg::ST_LOAD2: begin
        sw_d    = r_rd_q;
        state_d = llmt_pkg::ST_MAC;
      end
      llmt_pkg::ST_MAC: begin
        if (pass_end) begin
          pend_d = ncy;
          atop_d = sh_word[tidx];
          sw_d   = sw_q >> 1;
          bi_d   = bi_inc;
          if (bi_q == (p_q - EW'(1))) begin
            state_d = llmt_pkg::ST_SUB2;
          end else if (bi_inc[LW-1:0] == '0) begin
            state_d = llmt_pkg::ST_LOAD;
          end
        end
      end
      llmt_pkg::ST_SUB2, llmt_pkg::ST_FOLD: begin
        if (pass_end) begin
          pend_d = ncy;
          if (ncy) begin
            state_d = llmt_pkg::ST_FOLD;
          end else begin
            it_d = it_q - EW'(1);
            if (it_q == EW'(1)) begin
              zr_d    = 1'b1;
              on_d    = 1'b1;
              state_d = llmt_pkg::ST_CHECK;
            end else begin
              state_d = llmt_pkg::ST_COPY;
            end
          end
        end
      end
      llmt_pkg::ST_CHECK: begin
        if (sv_q) begin
          zr_d = zr_n;
          on_d = on_n;
        end
        if (pass_end) begin
          pr_d    = zr_n || on_n;
          state_d = llmt_pkg::ST_DONE;
        end
      end
      llmt_pkg::ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          res_d   = pr_q;
          state_d = llmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = llmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llmt_pkg::ST_IDLE;
      rk_q    <= '0;
      sv_q    <= 1'b0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rk_q    <= rk_d;
      sv_q    <= sv_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    nw_q   <= nw_d;
    tb_q   <= tb_d;
    it_q   <= it_d;
    bi_q   <= bi_d;
    sw_q   <= sw_d;
    wk_q   <= wk_d;
    cy_q   <= cy_d;
    am_q   <= am_d;
    atop_q <= atop_d;
    zr_q   <= zr_d;
    on_q   <= on_d;
    pr_q   <= pr_d;
    res_q  <= res_d;
  end

  // a residue is copied or checked only once its end-around carry is folded
  a_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == llmt_pkg::ST_COPY) || (state_q == llmt_pkg::ST_CHECK)) |-> !pend_q)
    else $error("pending carry at copy or check");

  // the write stage stays within the words in use
  a_wk_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> (CW'(wk_q) < nw_q))
    else $error("write word index out of range");

  // multiplier bit stays below p
  a_bit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == llmt_pkg::ST_MAC) |-> (bi_q < p_q))
    else $error("multiplier bit out of range");

  // small exponents are answered without any pass
  a_small_exp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (exponent_i < EW'(3))) |=> (state_q == llmt_pkg::ST_DONE))
    else $error("small exponent not answered at once");

  // a step is only begun when one is left to do
  a_steps_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == llmt_pkg::ST_COPY) |-> (it_q != '0))
    else $error("step count exhausted at copy");

endmodule
